[rtl/a2p_pkg.sv]
// a2p_pkg: shared types and constants for the ADC-to-power converter.
// Used by a2p_ctrl, a2p_datapath and adc_to_power_piecewise_linear.
// Depends on nothing.
`default_nettype none

package a2p_pkg;

    // Fixed field widths
    localparam int ADC_W   = 10;
    localparam int WATT_W  = 12;
    localparam int IDX_W   = 7;
    localparam int POWER_W = 16;
    localparam int SLOPE_W = 16;
    localparam int CNT_W   = 8;
    localparam int CFG_W   = 16;

    // Raw power before clipping: watts*16 plus extrapolated term
    localparam int VAL_W   = 23;

    // Restoring divider produces the 16 quotient bits
    localparam int DIV_STEPS = 16;
    localparam int DCNT_W    = 5;

    // Configuration register indexes
    localparam logic CFG_ENTRIES_USED = 1'b0;
    localparam logic CFG_SLOPE        = 1'b1;

    // Input kinds (tuser)
    localparam logic ACT_WRITE   = 1'b0;
    localparam logic ACT_CONVERT = 1'b1;

    // Datapath commands
    typedef enum logic [4:0] {
        OP_NONE,
        OP_WRITE,
        OP_START,
        OP_EXT_MUL,
        OP_EXT_SUM,
        OP_SEARCH_INIT,
        OP_RD_MID,
        OP_STEP,
        OP_RD_LO,
        OP_EXACT,
        OP_RD_FIRST,
        OP_TAKE_FIRST,
        OP_RD_NEXT,
        OP_FLAT,
        OP_MUL,
        OP_SUM,
        OP_ZERO,
        OP_SAT,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_TAKE_QUO,
        OP_EMIT
    } a2p_op_t;

    // Datapath status toward the controller
    typedef struct packed {
        logic above_last;   // sample above last point in use
        logic search_open;  // lo < hi
        logic mid_le;       // read point adc <= sample
        logic hit;          // read point adc == sample
        logic below;        // read point adc > sample, or lo at last
        logic flat;         // neighbour adc not above found point
        logic num_neg;      // interpolation numerator negative
        logic quo_over;     // quotient would exceed 16 bits
        logic div_done;     // divider finished
    } a2p_status_t;

    // Converted result
    typedef struct packed {
        logic [POWER_W-1:0] power;
        logic               exact_hit;
        logic               beyond_table;
        logic               saturated;
    } a2p_result_t;

endpackage

`default_nettype wire

[rtl/a2p_ctrl.sv]
// a2p_ctrl: sequencer for table writes, extrapolation, binary search, interpolation and divide.
// Drives datapath commands from a2p_datapath status; uses a2p_pkg types.
`default_nettype none

module a2p_ctrl
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_action,
    output logic                       in_ready,
    input  wire logic                  out_busy,
    input  wire a2p_pkg::a2p_status_t  status,
    output a2p_pkg::a2p_op_t           op
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LAST,
        S_EXT,
        S_SEARCH,
        S_CMP,
        S_A0,
        S_FIRST,
        S_A1,
        S_SUM,
        S_CHK,
        S_DIV,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Choose command and next state
    always_comb
    begin
        op         = a2p_pkg::OP_NONE;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_action == a2p_pkg::ACT_CONVERT)
                    begin
                        op         = a2p_pkg::OP_START;
                        state_next = S_LAST;
                    end
                    else
                    begin
                        op = a2p_pkg::OP_WRITE;
                    end
                end
            end
            S_LAST:
            begin
                if (status.above_last)
                begin
                    op         = a2p_pkg::OP_EXT_MUL;
                    state_next = S_EXT;
                end
                else
                begin
                    op         = a2p_pkg::OP_SEARCH_INIT;
                    state_next = S_SEARCH;
                end
            end
            S_EXT:
            begin
                op         = a2p_pkg::OP_EXT_SUM;
                state_next = S_OUT;
            end
            S_SEARCH:
            begin
                if (status.search_open)
                begin
                    op         = a2p_pkg::OP_RD_MID;
                    state_next = S_CMP;
                end
                else
                begin
                    op         = a2p_pkg::OP_RD_LO;
                    state_next = S_A0;
                end
            end
            S_CMP:
            begin
                op         = a2p_pkg::OP_STEP;
                state_next = S_SEARCH;
            end
            S_A0:
            begin
                priority if (status.hit)
                begin
                    op         = a2p_pkg::OP_EXACT;
                    state_next = S_OUT;
                end
                else if (status.below)
                begin
                    op         = a2p_pkg::OP_RD_FIRST;
                    state_next = S_FIRST;
                end
                else
                begin
                    op         = a2p_pkg::OP_RD_NEXT;
                    state_next = S_A1;
                end
            end
            S_FIRST:
            begin
                op         = a2p_pkg::OP_TAKE_FIRST;
                state_next = S_OUT;
            end
            S_A1:
            begin
                if (status.flat)
                begin
                    op         = a2p_pkg::OP_FLAT;
                    state_next = S_OUT;
                end
                else
                begin
                    op         = a2p_pkg::OP_MUL;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                op         = a2p_pkg::OP_SUM;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                priority if (status.num_neg)
                begin
                    op         = a2p_pkg::OP_ZERO;
                    state_next = S_OUT;
                end
                else if (status.quo_over)
                begin
                    op         = a2p_pkg::OP_SAT;
                    state_next = S_OUT;
                end
                else
                begin
                    op         = a2p_pkg::OP_DIV_INIT;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    op         = a2p_pkg::OP_TAKE_QUO;
                    state_next = S_OUT;
                end
                else
                begin
                    op = a2p_pkg::OP_DIV_STEP;
                end
            end
            S_OUT:
            begin
                if (!out_busy)
                begin
                    op         = a2p_pkg::OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[rtl/a2p_datapath.sv]
// a2p_datapath: calibration table memory, search indices, multipliers and divider.
// Executes a2p_ctrl commands; uses a2p_pkg types and constants.
`default_nettype none

module a2p_datapath
#(
    parameter int TABLE_DEPTH = 128
)
(
    input  wire logic                              clk,
    input  wire a2p_pkg::a2p_op_t                  op,
    input  wire logic [a2p_pkg::IDX_W-1:0]         entry_index,
    input  wire logic [a2p_pkg::ADC_W-1:0]         entry_adc,
    input  wire logic [a2p_pkg::WATT_W-1:0]        entry_watts,
    input  wire logic [a2p_pkg::ADC_W-1:0]         sample,
    input  wire logic [a2p_pkg::CNT_W-1:0]         entries_used,
    input  wire logic [a2p_pkg::SLOPE_W-1:0]       slope,
    output a2p_pkg::a2p_status_t                   status,
    output a2p_pkg::a2p_result_t                   result
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int ENT_W = a2p_pkg::ADC_W + a2p_pkg::WATT_W;
    localparam int ADC_W = a2p_pkg::ADC_W;
    localparam int WAT_W = a2p_pkg::WATT_W;
    localparam int VAL_W = a2p_pkg::VAL_W;

    // Table memory: watts in upper bits, adc in lower bits
    logic [ENT_W-1:0] mem [TABLE_DEPTH];
    logic [ENT_W-1:0] rdata_reg;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;

    logic [ADC_W-1:0] rd_adc;
    logic [WAT_W-1:0] rd_watts;

    logic [AW-1:0]    last_w;
    logic [AW:0]      mid_sum;
    logic [AW-1:0]    mid_w;

    logic [ADC_W-1:0]    sample_reg;
    logic [AW-1:0]       last_reg;
    logic [AW-1:0]       lo_reg;
    logic [AW-1:0]       hi_reg;
    logic [AW-1:0]       mid_reg;
    logic [ADC_W-1:0]    a0_reg;
    logic [WAT_W-1:0]    w0_reg;
    logic [ADC_W-1:0]    span_reg;
    logic [25:0]         ext_prod_reg;
    logic [21:0]         prod_a_reg;
    logic signed [23:0]  prod_b_reg;
    logic signed [24:0]  sum_reg;
    logic [ADC_W-1:0]    rem_reg;
    logic [15:0]         quo_reg;
    logic [a2p_pkg::DCNT_W-1:0] cnt_reg;
    logic [VAL_W-1:0]    val_reg;
    logic                exact_reg;
    logic                beyond_reg;

    logic [ADC_W-1:0]    span_w;
    logic [ADC_W-1:0]    diff_adc;
    logic signed [12:0]  dwatt_w;
    logic [ADC_W:0]      rem_sh;
    logic                rem_ge;
    logic [27:0]         num_w;

    assign rd_adc   = rdata_reg[ADC_W-1:0];
    assign rd_watts = rdata_reg[ENT_W-1:ADC_W];

    // Clamp entry count to 2..TABLE_DEPTH, give last index
    always_comb
    begin
        priority if (entries_used < a2p_pkg::CNT_W'(2))
        begin
            last_w = AW'(1);
        end
        else if (32'(entries_used) > TABLE_DEPTH)
        begin
            last_w = AW'(TABLE_DEPTH - 1);
        end
        else
        begin
            last_w = AW'(entries_used - a2p_pkg::CNT_W'(1));
        end
    end

    // Upper midpoint of the search window
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} + (AW+1)'(1);
    assign mid_w   = mid_sum[AW:1];

    // Read address per command
    always_comb
    begin
        unique case (op)
            a2p_pkg::OP_START:    rd_addr = last_w;
            a2p_pkg::OP_RD_MID:   rd_addr = mid_w;
            a2p_pkg::OP_RD_LO:    rd_addr = lo_reg;
            a2p_pkg::OP_RD_FIRST: rd_addr = '0;
            a2p_pkg::OP_RD_NEXT:  rd_addr = lo_reg + AW'(1);
            default:              rd_addr = last_reg;
        endcase
    end

    // Drop writes beyond the table
    assign wr_en = (op == a2p_pkg::OP_WRITE) && (32'(entry_index) < TABLE_DEPTH);

    // Table write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[AW'(entry_index)] <= {entry_watts, entry_adc};
        end
        rdata_reg <= mem[rd_addr];
    end

    // Interpolation operands
    assign span_w   = rd_adc - a0_reg;
    assign diff_adc = sample_reg - a0_reg;
    assign dwatt_w  = $signed({1'b0, rd_watts}) - $signed({1'b0, w0_reg});
    assign num_w    = {sum_reg[23:0], 4'b0000};

    // One restoring divide step
    assign rem_sh = {rem_reg, quo_reg[15]};
    assign rem_ge = (rem_sh >= {1'b0, span_reg});

    // Execute commands
    always_ff @(posedge clk)
    begin
        unique case (op)
            a2p_pkg::OP_START:
            begin
                sample_reg <= sample;
                last_reg   <= last_w;
                exact_reg  <= 1'b0;
                beyond_reg <= 1'b0;
            end
            a2p_pkg::OP_EXT_MUL:
            begin
                ext_prod_reg <= (sample_reg - rd_adc) * slope;
                w0_reg       <= rd_watts;
                beyond_reg   <= 1'b1;
            end
            a2p_pkg::OP_EXT_SUM:
            begin
                val_reg <= VAL_W'({w0_reg, 4'b0000}) + VAL_W'(ext_prod_reg[25:4]);
            end
            a2p_pkg::OP_SEARCH_INIT:
            begin
                lo_reg <= '0;
                hi_reg <= last_reg;
            end
            a2p_pkg::OP_RD_MID:
            begin
                mid_reg <= mid_w;
            end
            a2p_pkg::OP_STEP:
            begin
                if (rd_adc <= sample_reg)
                begin
                    lo_reg <= mid_reg;
                end
                else
                begin
                    hi_reg <= mid_reg - AW'(1);
                end
            end
            a2p_pkg::OP_EXACT:
            begin
                val_reg   <= VAL_W'({rd_watts, 4'b0000});
                exact_reg <= 1'b1;
            end
            a2p_pkg::OP_RD_NEXT:
            begin
                a0_reg <= rd_adc;
                w0_reg <= rd_watts;
            end
            a2p_pkg::OP_TAKE_FIRST:
            begin
                val_reg <= VAL_W'({rd_watts, 4'b0000});
            end
            a2p_pkg::OP_FLAT:
            begin
                val_reg <= VAL_W'({w0_reg, 4'b0000});
            end
            a2p_pkg::OP_MUL:
            begin
                span_reg   <= span_w;
                prod_a_reg <= w0_reg * span_w;
                prod_b_reg <= $signed({1'b0, diff_adc}) * dwatt_w;
            end
            a2p_pkg::OP_SUM:
            begin
                sum_reg <= $signed({3'b000, prod_a_reg}) + {prod_b_reg[23], prod_b_reg};
            end
            a2p_pkg::OP_ZERO:
            begin
                val_reg <= '0;
            end
            a2p_pkg::OP_SAT:
            begin
                val_reg <= VAL_W'(32'd65536);
            end
            a2p_pkg::OP_DIV_INIT:
            begin
                rem_reg <= num_w[25:16];
                quo_reg <= num_w[15:0];
                cnt_reg <= a2p_pkg::DCNT_W'(a2p_pkg::DIV_STEPS);
            end
            a2p_pkg::OP_DIV_STEP:
            begin
                if (rem_ge)
                begin
                    rem_reg <= ADC_W'(rem_sh - {1'b0, span_reg});
                end
                else
                begin
                    rem_reg <= rem_sh[ADC_W-1:0];
                end
                quo_reg <= {quo_reg[14:0], rem_ge};
                cnt_reg <= cnt_reg - a2p_pkg::DCNT_W'(1);
            end
            a2p_pkg::OP_TAKE_QUO:
            begin
                val_reg <= VAL_W'(quo_reg);
            end
            default:
            begin
            end
        endcase
    end

    // Status toward the controller
    always_comb
    begin
        status.above_last  = (sample_reg > rd_adc);
        status.search_open = (lo_reg < hi_reg);
        status.mid_le      = (rd_adc <= sample_reg);
        status.hit         = (rd_adc == sample_reg);
        status.below       = (rd_adc > sample_reg) || (lo_reg >= last_reg);
        status.flat        = (rd_adc <= a0_reg);
        status.num_neg     = sum_reg[24];
        status.quo_over    = (num_w >= {2'b00, span_reg, 16'h0000});
        status.div_done    = (cnt_reg == '0);
    end

    // Clip to 16 bits
    always_comb
    begin
        result.saturated    = |val_reg[VAL_W-1:16];
        result.power        = result.saturated ? 16'hFFFF : val_reg[15:0];
        result.exact_hit    = exact_reg;
        result.beyond_table = beyond_reg;
    end

endmodule

`default_nettype wire

[rtl/adc_to_power_piecewise_linear.sv]
// adc_to_power_piecewise_linear: top level, stream ports, config registers, output stage.
// Instantiates a2p_ctrl and a2p_datapath; uses a2p_pkg.
//
//  channel | direction | handshake          | payload
//  s_*     | in        | s_tvalid/s_tready  | tdata: index, adc, watts, sample; tuser: action
//  m_*     | out       | m_tvalid/m_tready  | tdata: power; tuser: exact, beyond, saturated
//  cfg_*   | in        | cfg_we             | cfg_index, cfg_data
//
// A table write is done in the idle state. A conversion above the last point extrapolates
// from the last entry with the slope register; an interpolated one uses one memory read
// per search step and a one-bit-per-cycle divider. Reset clears control state and sets
// the configuration registers to defaults; table contents are undefined until written.
// A finished result waits in the output register while the next request is taken.
`default_nettype none

module adc_to_power_piecewise_linear
#(
    parameter int TABLE_DEPTH = 128
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // entry_index[6:0], entry_adc[16:7],
                                        // entry_watts[28:17], sample[38:29]
    input  wire logic        s_tuser,   // action[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // power[15:0]
    output logic [2:0]       m_tuser,   // exact_hit[0], beyond_table[1], saturated[2]
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [a2p_pkg::CNT_W-1:0]   entries_used_reg;
    logic [a2p_pkg::SLOPE_W-1:0] slope_reg;

    logic                   m_tvalid_reg;
    logic [15:0]            m_tdata_reg;
    logic [2:0]             m_tuser_reg;

    logic                   out_busy;
    logic                   in_ready;
    a2p_pkg::a2p_op_t       op;
    a2p_pkg::a2p_status_t   status;
    a2p_pkg::a2p_result_t   result;

    assign out_busy = m_tvalid_reg && !m_tready;
    assign s_tready = in_ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_used_reg <= a2p_pkg::CNT_W'(90);
            slope_reg        <= a2p_pkg::SLOPE_W'(1152);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                a2p_pkg::CFG_ENTRIES_USED: entries_used_reg <= cfg_data[7:0];
                a2p_pkg::CFG_SLOPE:        slope_reg        <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Output register: load on emit, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (op == a2p_pkg::OP_EMIT)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op == a2p_pkg::OP_EMIT)
        begin
            m_tdata_reg <= result.power;
            m_tuser_reg <= {result.saturated, result.beyond_table, result.exact_hit};
        end
    end

    a2p_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_action (s_tuser),
        .in_ready  (in_ready),
        .out_busy  (out_busy),
        .status    (status),
        .op        (op)
    );

    a2p_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath
    (
        .clk          (clk),
        .op           (op),
        .entry_index  (s_tdata[6:0]),
        .entry_adc    (s_tdata[16:7]),
        .entry_watts  (s_tdata[28:17]),
        .sample       (s_tdata[38:29]),
        .entries_used (entries_used_reg),
        .slope        (slope_reg),
        .status       (status),
        .result       (result)
    );

endmodule

`default_nettype wire
